/* hdl/mhfp_pkg.sv */
package mhfp_pkg;

  // header layout
  localparam int unsigned HdrLen   = 12;
  localparam int unsigned HdrIdxW  = 4;
  localparam int unsigned MagicLen = 4;

  // payload size bounds
  localparam logic [15:0] PayloadLimit = 16'd2048;
  localparam int unsigned CountW       = 12;
  localparam int unsigned IndexW       = 11;

  // queue between parser and output side
  localparam int unsigned QDepth = 2;

  // register reset values
  localparam logic [31:0] MagicWordReset  = 32'h4A43_4948;
  localparam logic [11:0] MaxPayloadReset = 12'd2048;
  localparam int unsigned CfgDataW        = 32;

  typedef enum logic {
    KIND_BYTE  = 1'b0,
    KIND_RESET = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_PAYLOAD  = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_SIZE_ERR = 2'd2
  } status_e;

  typedef enum logic {
    CFG_MAGIC_WORD  = 1'b0,
    CFG_MAX_PAYLOAD = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
  } in_word_t;

  typedef struct packed {
    status_e            status;
    logic [15:0]        command_id;
    logic [15:0]        version;
    logic [7:0]         payload_byte;
    logic [IndexW-1:0]  byte_index;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [11:0] max_payload;
  } cfg_t;

endpackage

/* hdl/mhfp_front.sv */
module mhfp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mhfp_pkg::cfg_t     cfg_i,
  input  logic               in_fire_i,
  input  mhfp_pkg::in_word_t in_word_i,
  output logic               push_o,
  output mhfp_pkg::out_word_t push_word_o
);

  logic [7:0]                    win_q [mhfp_pkg::HdrLen];
  logic [7:0]                    win_d [mhfp_pkg::HdrLen];
  logic [7:0]                    nwin  [mhfp_pkg::HdrLen];
  logic [mhfp_pkg::HdrIdxW-1:0]  fill_q, fill_d;
  logic                          recv_q, recv_d;
  logic [mhfp_pkg::CountW-1:0]   size_q, size_d;
  logic [mhfp_pkg::CountW-1:0]   count_q, count_d;

  logic        magic_ok;
  logic [31:0] total;
  logic [15:0] size16;
  logic [15:0] limit;
  logic        last_byte;
  logic [15:0] hdr_version;
  logic [15:0] hdr_command;

  // window with the incoming byte placed at the fill position
  always_comb begin
    for (int i = 0; i < mhfp_pkg::HdrLen; i++) begin
      nwin[i] = win_q[i];
    end
    nwin[fill_q] = in_word_i.data_byte;
  end

  // header decode on the completed window
  assign magic_ok = ({nwin[3], nwin[2], nwin[1], nwin[0]} == cfg_i.magic_word);
  assign total    = {nwin[11], nwin[10], nwin[9], nwin[8]};
  assign size16   = total[15:0] - 16'(mhfp_pkg::HdrLen);
  assign limit    = ({4'd0, cfg_i.max_payload} < mhfp_pkg::PayloadLimit)
                    ? {4'd0, cfg_i.max_payload} : mhfp_pkg::PayloadLimit;

  // header fields come from the held window while a payload streams
  assign hdr_version = recv_q ? {win_q[5], win_q[4]} : {nwin[5], nwin[4]};
  assign hdr_command = recv_q ? {win_q[7], win_q[6]} : {nwin[7], nwin[6]};

  assign last_byte = ({1'b0, count_q} + 13'd1) >= {1'b0, size_q};

  // parser state update and result classification
  always_comb begin
    win_d   = win_q;
    fill_d  = fill_q;
    recv_d  = recv_q;
    size_d  = size_q;
    count_d = count_q;
    push_o  = 1'b0;
    push_word_o.status       = mhfp_pkg::ST_PAYLOAD;
    push_word_o.command_id   = hdr_command;
    push_word_o.version      = hdr_version;
    push_word_o.payload_byte = 8'd0;
    push_word_o.byte_index   = '0;
    push_word_o.last         = 1'b1;

    if (in_fire_i) begin
      if (in_word_i.kind == mhfp_pkg::KIND_RESET) begin
        fill_d  = '0;
        recv_d  = 1'b0;
        size_d  = '0;
        count_d = '0;
      end else if (recv_q) begin
        push_o = 1'b1;
        push_word_o.payload_byte = in_word_i.data_byte;
        push_word_o.byte_index   = count_q[mhfp_pkg::IndexW-1:0];
        push_word_o.last         = last_byte;
        count_d = count_q + 1'b1;
        if (last_byte) begin
          fill_d  = '0;
          recv_d  = 1'b0;
          size_d  = '0;
          count_d = '0;
        end
      end else if (fill_q != mhfp_pkg::HdrIdxW'(mhfp_pkg::HdrLen - 1)) begin
        win_d  = nwin;
        fill_d = fill_q + 1'b1;
      end else if (!magic_ok) begin
        // drop the oldest byte and keep hunting
        for (int i = 0; i < mhfp_pkg::HdrLen - 1; i++) begin
          win_d[i] = nwin[i+1];
        end
        win_d[mhfp_pkg::HdrLen-1] = 8'd0;
      end else if (size16 > limit) begin
        push_o = 1'b1;
        push_word_o.status = mhfp_pkg::ST_SIZE_ERR;
        fill_d = '0;
      end else if (size16 == 16'd0) begin
        push_o = 1'b1;
        push_word_o.status = mhfp_pkg::ST_EMPTY;
        fill_d = '0;
      end else begin
        win_d   = nwin;
        fill_d  = '0;
        recv_d  = 1'b1;
        size_d  = size16[mhfp_pkg::CountW-1:0];
        count_d = '0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      recv_q  <= 1'b0;
      size_q  <= '0;
      count_q <= '0;
    end else begin
      fill_q  <= fill_d;
      recv_q  <= recv_d;
      size_q  <= size_d;
      count_q <= count_d;
    end
  end

  // header window bytes
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < mhfp_pkg::HdrLen; i++) begin
      win_q[i] <= win_d[i];
    end
  end

endmodule

/* hdl/mhfp_queue.sv */
module mhfp_queue #(
  parameter int unsigned Depth = mhfp_pkg::QDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mhfp_pkg::out_word_t push_word_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mhfp_pkg::out_word_t out_word_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  mhfp_pkg::out_word_t entries_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]       count_q;
  logic                pop;

  assign out_valid_o = (count_q != '0);
  assign full_o      = (count_q == (PtrW+1)'(Depth));
  assign pop         = out_valid_o && !out_stall_i;
  assign out_word_o  = entries_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // word storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

/* hdl/magic_header_frame_parser.sv */
// magic header frame parser: byte stream in, tagged payload words out
// a result is pushed into the output queue as its byte is taken and is offered in the next cycle if no older word waits
// throughput: one byte per cycle while in_stall_o is low; the two-word output queue absorbs one word of stall
// in_stall_o rises only while that queue holds two untaken words
// reset (rst_ni low, asynchronous) clears parser state, queue and registers;
// the header window bytes are not cleared and are rewritten before use
module magic_header_frame_parser #(
  parameter int unsigned QDepth = mhfp_pkg::QDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  mhfp_pkg::in_word_t      in_word_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output mhfp_pkg::out_word_t     out_word_o,
  input  logic                    cfg_we_i,
  input  mhfp_pkg::cfg_idx_e      cfg_idx_i,
  input  logic [mhfp_pkg::CfgDataW-1:0] cfg_data_i
);

  mhfp_pkg::cfg_t      cfg_q;
  mhfp_pkg::out_word_t push_word;
  logic                push;
  logic                full;
  logic                in_fire;

  assign in_stall_o = full;
  assign in_fire    = in_valid_i && !full;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_word  <= mhfp_pkg::MagicWordReset;
      cfg_q.max_payload <= mhfp_pkg::MaxPayloadReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mhfp_pkg::CFG_MAGIC_WORD:  cfg_q.magic_word  <= cfg_data_i[31:0];
        mhfp_pkg::CFG_MAX_PAYLOAD: cfg_q.max_payload <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // header hunt and payload classification
  mhfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_fire_i   (in_fire),
    .in_word_i   (in_word_i),
    .push_o      (push),
    .push_word_o (push_word)
  );

  // output queue
  mhfp_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

`ifndef ASSERT_OFF
  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> out_valid_o)
    else $error("pushed word not offered");

  a_reset_item_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_word_i.kind == mhfp_pkg::KIND_RESET) |-> !push)
    else $error("parser reset item produced a word");

  a_no_push_unaccepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> in_fire)
    else $error("word pushed without an accepted byte");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status != mhfp_pkg::ST_PAYLOAD) |-> out_word_o.last)
    else $error("frame status word not marked last");
`endif

endmodule

/* tb/magic_header_frame_parser_test.sv */
module magic_header_frame_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  mhfp_pkg::in_word_t            in_word_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  mhfp_pkg::out_word_t           out_word_o;
  logic                          cfg_we_i = 1'b0;
  mhfp_pkg::cfg_idx_e            cfg_idx_i = mhfp_pkg::CFG_MAGIC_WORD;
  logic [mhfp_pkg::CfgDataW-1:0] cfg_data_i = '0;

  magic_header_frame_parser DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // words waiting to be sent and results still owed by the parser
  mhfp_pkg::in_word_t  rx_words[$];
  mhfp_pkg::out_word_t pending_results[$];
  int        err_cnt = 0;
  int        item_cnt = 0;
  int        cycle_cnt = 0;

  // parser copy: registers and hunting state
  logic [31:0] magic_cfg = mhfp_pkg::MagicWordReset;
  logic [11:0] max_payload_cfg = mhfp_pkg::MaxPayloadReset;
  logic [7:0]  hdr_win[mhfp_pkg::HdrLen];
  int          win_fill = 0;
  bit          in_payload = 1'b0;
  logic [15:0] pay_size = '0;
  logic [11:0] pay_count = '0;

  // idle drawing, with calm stretches of no idling
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  int in_gap = 0;
  int out_hold = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 19) == 0) calm = ~calm;
    return calm ? 0 : int'($urandom_range(0, 14));
  endfunction

  function automatic void clear_parser();
    foreach (hdr_win[i]) hdr_win[i] = '0;
    win_fill = 0;
    in_payload = 1'b0;
    pay_size = '0;
    pay_count = '0;
  endfunction

  function automatic mhfp_pkg::out_word_t tagged_result(mhfp_pkg::status_e st,
                                                        logic [7:0] pb,
                                                        logic [mhfp_pkg::IndexW-1:0] idx,
                                                        logic lst);
    mhfp_pkg::out_word_t r;
    r.status       = st;
    r.command_id   = {hdr_win[7], hdr_win[6]};
    r.version      = {hdr_win[5], hdr_win[4]};
    r.payload_byte = pb;
    r.byte_index   = idx;
    r.last         = lst;
    return r;
  endfunction

  // predicts the result, if any, of one accepted word
  function automatic void parse_rx_word(mhfp_pkg::in_word_t w);
    logic [31:0] total;
    logic [15:0] lim;
    logic        lst;
    if (w.kind == mhfp_pkg::KIND_RESET) begin
      clear_parser();
      return;
    end
    // payload streaming
    if (in_payload) begin
      lst = (int'(pay_count) + 1 >= int'(pay_size));
      pending_results.push_back(tagged_result(mhfp_pkg::ST_PAYLOAD, w.data_byte,
                                              pay_count[mhfp_pkg::IndexW-1:0], lst));
      pay_count = pay_count + 1'b1;
      if (lst) clear_parser();
      return;
    end
    // header hunting in the sliding window
    if (win_fill >= mhfp_pkg::HdrLen) win_fill = mhfp_pkg::HdrLen - 1;
    hdr_win[win_fill] = w.data_byte;
    win_fill++;
    if (win_fill < mhfp_pkg::HdrLen) return;
    if ({hdr_win[3], hdr_win[2], hdr_win[1], hdr_win[0]} != magic_cfg) begin
      for (int i = 0; i < mhfp_pkg::HdrLen - 1; i++) hdr_win[i] = hdr_win[i + 1];
      hdr_win[mhfp_pkg::HdrLen - 1] = '0;
      win_fill = mhfp_pkg::HdrLen - 1;
      return;
    end
    total = {hdr_win[11], hdr_win[10], hdr_win[9], hdr_win[8]};
    pay_size = total[15:0] - 16'd12;
    lim = ({4'd0, max_payload_cfg} < mhfp_pkg::PayloadLimit) ? {4'd0, max_payload_cfg}
                                                             : mhfp_pkg::PayloadLimit;
    if (pay_size > lim) begin
      pending_results.push_back(tagged_result(mhfp_pkg::ST_SIZE_ERR, '0, '0, 1'b1));
      clear_parser();
    end else if (pay_size == 0) begin
      pending_results.push_back(tagged_result(mhfp_pkg::ST_EMPTY, '0, '0, 1'b1));
      clear_parser();
    end else begin
      in_payload = 1'b1;
      pay_count = '0;
    end
  endfunction

  // input side: one word at a time from rx_words, random gaps between words
  always @(posedge clk_i) begin
    logic               nv;
    mhfp_pkg::in_word_t nw;
    nv = in_valid_i;
    nw = in_word_i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        parse_rx_word(in_word_i);
        nv = 1'b0;
        in_gap = draw_wait(in_calm);
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (rx_words.size() > 0) begin
          nw = rx_words.pop_front();
          nv = 1'b1;
        end
      end
    end
    in_valid_i <= nv;
    in_word_i <= nw;
  end

  // output side: compare each taken word with the oldest prediction
  always @(posedge clk_i) begin
    mhfp_pkg::out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected word: %p", out_word_o);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_word_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_word_o.status);
          err_cnt++;
        end
        if (out_word_o.command_id !== want.command_id) begin
          $error("command_id: expected %h, got %h", want.command_id, out_word_o.command_id);
          err_cnt++;
        end
        if (out_word_o.version !== want.version) begin
          $error("version: expected %h, got %h", want.version, out_word_o.version);
          err_cnt++;
        end
        if (out_word_o.payload_byte !== want.payload_byte) begin
          $error("payload_byte: expected %h, got %h", want.payload_byte,
                 out_word_o.payload_byte);
          err_cnt++;
        end
        if (out_word_o.byte_index !== want.byte_index) begin
          $error("byte_index: expected %0d, got %0d", want.byte_index, out_word_o.byte_index);
          err_cnt++;
        end
        if (out_word_o.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_word_o.last);
          err_cnt++;
        end
      end
      out_hold = draw_wait(out_calm);
    end
    if (rst_ni && out_hold > 0) begin
      out_hold--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic add_byte(logic [7:0] b);
    mhfp_pkg::in_word_t w;
    w.kind = mhfp_pkg::KIND_BYTE;
    w.data_byte = b;
    rx_words.push_back(w);
    item_cnt++;
  endtask

  task automatic add_reset();
    mhfp_pkg::in_word_t w;
    w.kind = mhfp_pkg::KIND_RESET;
    w.data_byte = 8'($urandom_range(0, 255));
    rx_words.push_back(w);
    item_cnt++;
  endtask

  // header plus pay_n random payload bytes; keep < 0 sends all, else only the first keep
  task automatic add_frame(logic [31:0] mw, logic [15:0] ver, logic [15:0] cmd,
                           logic [31:0] total, int pay_n, int keep);
    logic [7:0] fb[$];
    for (int i = 0; i < 4; i++) fb.push_back(mw[8*i +: 8]);
    fb.push_back(ver[7:0]);
    fb.push_back(ver[15:8]);
    fb.push_back(cmd[7:0]);
    fb.push_back(cmd[15:8]);
    for (int i = 0; i < 4; i++) fb.push_back(total[8*i +: 8]);
    for (int i = 0; i < pay_n; i++) fb.push_back(8'($urandom_range(0, 255)));
    for (int i = 0; i < fb.size(); i++) begin
      if (keep >= 0 && i >= keep) break;
      add_byte(fb[i]);
    end
  endtask

  function automatic int cur_limit();
    return (max_payload_cfg < 12'd2048) ? int'(max_payload_cfg) : 2048;
  endfunction

  task automatic add_good_frame(int keep);
    int          sz;
    int          lim;
    logic [31:0] total;
    lim = cur_limit();
    if (lim == 0 || $urandom_range(0, 9) == 0) sz = 0;
    else sz = int'($urandom_range(1, (lim < 16) ? lim : 16));
    total = sz + 12;
    if ($urandom_range(0, 3) == 0) total[31:16] = 16'($urandom_range(0, 65535));
    add_frame(magic_cfg, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              total, sz, keep);
  endtask

  task automatic add_oversize_frame();
    int          sz;
    logic [31:0] total;
    if ($urandom_range(0, 3) == 0) begin
      total = $urandom_range(0, 11);
    end else begin
      sz = int'($urandom_range(cur_limit() + 1, 65535));
      total = {16'($urandom_range(0, 65535)), 16'(sz + 12)};
    end
    add_frame(magic_cfg, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              total, 0, -1);
  endtask

  // mostly clean frames with random content, the rest noise and broken frames
  task automatic add_random(int count);
    int target;
    int pick;
    int n;
    target = item_cnt + count;
    while (item_cnt < target) begin
      pick = int'($urandom_range(0, 99));
      if (pick < 60) begin
        add_good_frame(-1);
      end else if (pick < 70) begin
        add_oversize_frame();
      end else if (pick < 80) begin
        n = int'($urandom_range(1, 8));
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 2) == 0) add_byte(magic_cfg[8*(i % 4) +: 8]);
          else add_byte(8'($urandom_range(0, 255)));
        end
      end else if (pick < 88) begin
        add_reset();
      end else if (pick < 96) begin
        add_good_frame(int'($urandom_range(1, 20)));
        add_reset();
      end else begin
        add_frame(magic_cfg ^ (32'h1 << $urandom_range(0, 31)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  32'd14, 2, -1);
      end
    end
  endtask

  // block fully drained: nothing queued, nothing offered, nothing owed
  task automatic wait_idle();
    do @(negedge clk_i);
    while (rx_words.size() != 0 || in_valid_i || pending_results.size() != 0);
  endtask

  task automatic write_reg(mhfp_pkg::cfg_idx_e idx, logic [mhfp_pkg::CfgDataW-1:0] d);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      mhfp_pkg::CFG_MAGIC_WORD:  magic_cfg = d;
      mhfp_pkg::CFG_MAX_PAYLOAD: max_payload_cfg = d[11:0];
      default: ;
    endcase
  endtask

  task automatic reconfigure(logic [31:0] mw, logic [11:0] mp);
    wait_idle();
    repeat (4) @(posedge clk_i);
    write_reg(mhfp_pkg::CFG_MAGIC_WORD, mw);
    write_reg(mhfp_pkg::CFG_MAX_PAYLOAD, {20'd0, mp});
    @(negedge clk_i);
  endtask

  initial begin
    clear_parser();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values written back explicitly
    reconfigure(mhfp_pkg::MagicWordReset, mhfp_pkg::MaxPayloadReset);

    // directed: noise, reset mid-header, empty frame, one-byte frame
    add_byte(8'hFF);
    add_frame(magic_cfg, 16'hFFFF, 16'hFFFF, 32'd20, 0, 4);
    add_reset();
    add_frame(magic_cfg, 16'hFFFF, 16'h0000, 32'd12, 0, -1);
    add_frame(magic_cfg, 16'h0000, 16'hFFFF, 32'd13, 1, -1);
    rx_words[rx_words.size() - 1].data_byte = 8'h00;
    add_random(100);
    // longer payload than the random frames carry
    add_frame(magic_cfg, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              32'd112, 100, -1);

    // all-zero magic, nothing but empty frames fit
    reconfigure(32'h0000_0000, 12'd0);
    add_random(70);

    // all-ones magic, register above the hard limit
    reconfigure(32'hFFFF_FFFF, 12'hFFF);
    add_frame(magic_cfg, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              32'd2061, 0, -1);
    add_random(90);

    // random magic, tight limit
    reconfigure($urandom(), 12'($urandom_range(1, 40)));
    add_random(100);

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
